// ----- sv/tta_pkg.sv -----
// ----------------------------------------------------------------------------
// tta_pkg
// Shared types and constants of the triangle tangent accumulator.
// ----------------------------------------------------------------------------
package tta_pkg;

  localparam int unsigned VerticesDef = 1024;
  localparam logic [15:0] DetEpsilonReset = 16'd66;

  // register index of det_epsilon on the configuration port
  localparam logic RegDetEpsilon = 1'b0;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpAccum = 2'd1,
    OpRead  = 2'd2,
    OpNop   = 2'd3
  } tta_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [9:0]         vertex_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } tta_in_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               triangle_skipped;
    logic [15:0]        share_count;
  } tta_out_t;

  // request to the divider: unsigned dividend and divisor, sign of the quotient
  typedef struct packed {
    logic [79:0] dividend;
    logic [63:0] divisor;
    logic        neg;
  } tta_div_req_t;

endpackage

// ----- sv/tta_mul.sv -----
// ----------------------------------------------------------------------------
// tta_mul
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module tta_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- sv/tta_div.sv -----
// ----------------------------------------------------------------------------
// tta_div
// Bit-serial restoring divider with a 32-bit quotient, saturated to signed
// 32 bits after the sign is applied.
// ----------------------------------------------------------------------------
module tta_div
  import tta_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tta_div_req_t       req_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [64:0] rem_q;
  logic [31:0] low_q;
  logic [31:0] q_q;
  logic [63:0] d_q;
  logic        big_q, neg_q;

  logic        big;
  logic [64:0] trial;
  logic [65:0] diff;

  // quotient of 2^32 or more saturates at once
  assign big   = {16'h0, req_i.dividend} >= {req_i.divisor, 32'h0};
  assign trial = {rem_q[63:0], low_q[31]};
  assign diff  = {1'b0, trial} - {2'b00, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !big;
        done_q <= big;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q   <= req_i.divisor;
      neg_q <= req_i.neg;
      big_q <= big;
      rem_q <= {17'h0, req_i.dividend[79:32]};
      low_q <= req_i.dividend[31:0];
      q_q   <= 32'h0;
    end else if (busy_q) begin
      low_q <= {low_q[30:0], 1'b0};
      if (!diff[65]) begin
        rem_q <= diff[64:0];
        q_q   <= {q_q[30:0], 1'b1};
      end else begin
        rem_q <= trial;
        q_q   <= {q_q[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      if (big_q || (q_q > 32'h8000_0000)) begin
        quot_o = 32'sh8000_0000;
      end else begin
        quot_o = -$signed(q_q);
      end
    end else begin
      if (big_q || q_q[31]) begin
        quot_o = 32'sh7FFF_FFFF;
      end else begin
        quot_o = $signed(q_q);
      end
    end
  end

  assign done_o = done_q;

endmodule

// ----- sv/triangle_tangent_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_accumulator_unit
// Per-vertex tangent and bitangent accumulation in signed Q16.16.
// ----------------------------------------------------------------------------
// One item is taken while busy is low. Its result appears on result_o for one
// cycle with done_o and must be taken then, as the receiver cannot stall. A load
// or unused operation leaves busy low. A read of a vertex with no count ends
// without a division, else it runs six divisions. A triangle runs the corner
// fetch, fourteen multiplies, the determinant check, six divisions, an update
// of each corner and the result, and stops after the check when it is skipped.
// A division whose quotient is 2^32 or more skips the bit-serial steps of the
// 32-step divider. The shared multiplier is run fourteen times per triangle and
// the single-port sum memory is visited once per corner. The vertex and sum
// memories hold no reset value.
// ----------------------------------------------------------------------------
module triangle_tangent_accumulator_unit
  import tta_pkg::*;
#(
  parameter int unsigned VERTICES = VerticesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  tta_in_t     in_item_i,
  output logic        done_o,
  output tta_out_t    result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam logic [16:0] VertLim = 17'(VERTICES);

  typedef enum logic [11:0] {
    StIdle    = 12'b0000_0000_0001,
    StLdA     = 12'b0000_0000_0010,
    StLdB     = 12'b0000_0000_0100,
    StLdC     = 12'b0000_0000_1000,
    StDelta   = 12'b0000_0001_0000,
    StMul     = 12'b0000_0010_0000,
    StDet     = 12'b0000_0100_0000,
    StDivIss  = 12'b0000_1000_0000,
    StDivWait = 12'b0001_0000_0000,
    StRmwRd   = 12'b0010_0000_0000,
    StRmwWr   = 12'b0100_0000_0000,
    StRdSum   = 12'b1000_0000_0000
  } tta_state_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } tta_attr_t;

  typedef struct packed {
    logic [5:0][47:0] sums;
    logic [15:0]      count;
  } tta_sum_t;

  function automatic logic [AW-1:0] to_addr(input logic [9:0] idx);
    return AW'(idx);
  endfunction

  function automatic logic in_range(input logic [9:0] idx);
    return {7'h0, idx} < VertLim;
  endfunction

  function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] r;
    r = {a[31], a} - {b[31], b};
    if (r[32] != r[31]) begin
      return r[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] s,
                                            input logic signed [31:0] t);
    logic [48:0] r;
    r = {s[47], s} + {{17{t[31]}}, t};
    if (r[48] != r[47]) begin
      return r[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end
    return r[47:0];
  endfunction

  // configuration
  logic [15:0] eps_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegDetEpsilon);
  assign prdata = (paddr[2] == RegDetEpsilon) ? {16'h0, eps_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= DetEpsilonReset;
    end else if (cfg_wr) begin
      eps_q <= pwdata[15:0];
    end
  end

  // control state
  tta_state_e state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [1:0] kc_q, kc_d;
  logic [3:0] mstep_q, mstep_d;
  logic       done_q, done_d;
  tta_out_t   result_q, result_d;
  logic       mv_q;
  logic [3:0] mj_q;

  // payload
  tta_in_t            item_q;
  tta_attr_t          a_q;
  logic signed [31:0] p_q [3];
  logic signed [31:0] qd_q [3];
  logic signed [31:0] pu_q, pv_q, qu_q, qv_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] num_q [7];
  logic signed [31:0] res_q [6];

  // memories
  tta_attr_t attr_mem [VERTICES];
  tta_sum_t  sum_mem  [VERTICES];
  tta_attr_t attr_rdata_q;
  tta_sum_t  sum_rdata_q;
  logic [AW-1:0] attr_raddr, sum_raddr, sum_waddr;
  logic          attr_we, sum_we;
  tta_attr_t     attr_wdata;
  tta_sum_t      sum_wdata;

  // strobes
  logic take_item, take_a, take_p, take_q, take_res;

  // shared units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_done;
  tta_div_req_t       div_req;
  logic signed [31:0] div_quot;

  tta_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  tta_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  logic [9:0]         corner;
  logic signed [63:0] det, lim;
  logic               det_skip;
  logic [2:0]         num_sel;
  logic signed [63:0] num_sel_v;
  logic [47:0]        sum_sel, sum_mag;
  logic [63:0]        num_mag, det_mag;

  assign busy = (state_q != StIdle);

  always_comb begin
    case (kc_q)
      2'd0:    corner = item_q.corner_a;
      2'd1:    corner = item_q.corner_b;
      default: corner = item_q.corner_c;
    endcase
  end

  assign det      = num_q[0];
  assign lim      = 64'({eps_q, 16'h0});
  assign det_skip = (det == 64'sd0) || ((det < lim) && (det > -lim));

  // divider operands
  assign num_sel   = 3'(k_q + 3'd1);
  assign num_sel_v = num_q[num_sel];
  assign num_mag   = num_sel_v[63] ? 64'(-num_sel_v) : 64'(num_sel_v);
  assign det_mag   = det[63] ? 64'(-det) : 64'(det);
  assign sum_sel   = sum_rdata_q.sums[3'd5 - k_q];
  assign sum_mag   = sum_sel[47] ? 48'(-sum_sel) : sum_sel;

  always_comb begin
    if (item_q.operation == OpRead) begin
      div_req.dividend = 80'(sum_mag);
      div_req.divisor  = 64'(sum_rdata_q.count);
      div_req.neg      = sum_sel[47];
    end else begin
      div_req.dividend = {num_mag, 16'h0};
      div_req.divisor  = det_mag;
      div_req.neg      = num_sel_v[63] ^ det[63];
    end
  end

  // multiplier schedule: det, then tangent and bitangent numerators, two terms each
  always_comb begin
    case (mstep_q)
      4'd0:    begin mul_a = pu_q;     mul_b = qv_q; end
      4'd1:    begin mul_a = qu_q;     mul_b = pv_q; end
      4'd2:    begin mul_a = p_q[0];   mul_b = qv_q; end
      4'd3:    begin mul_a = qd_q[0];  mul_b = pv_q; end
      4'd4:    begin mul_a = p_q[1];   mul_b = qv_q; end
      4'd5:    begin mul_a = qd_q[1];  mul_b = pv_q; end
      4'd6:    begin mul_a = p_q[2];   mul_b = qv_q; end
      4'd7:    begin mul_a = qd_q[2];  mul_b = pv_q; end
      4'd8:    begin mul_a = qd_q[0];  mul_b = pu_q; end
      4'd9:    begin mul_a = p_q[0];   mul_b = qu_q; end
      4'd10:   begin mul_a = qd_q[1];  mul_b = pu_q; end
      4'd11:   begin mul_a = p_q[1];   mul_b = qu_q; end
      4'd12:   begin mul_a = qd_q[2];  mul_b = pu_q; end
      4'd13:   begin mul_a = p_q[2];   mul_b = qu_q; end
      default: begin mul_a = 32'sd0;   mul_b = 32'sd0; end
    endcase
  end

  // memory addressing and write data
  always_comb begin
    unique case (state_q)
      StLdA:   attr_raddr = to_addr(item_q.corner_a);
      StLdB:   attr_raddr = to_addr(item_q.corner_b);
      default: attr_raddr = to_addr(item_q.corner_c);
    endcase
    unique case (state_q)
      StIdle:           sum_raddr = to_addr(in_item_i.vertex_index);
      StRmwRd, StRmwWr: sum_raddr = to_addr(corner);
      default:          sum_raddr = to_addr(item_q.vertex_index);
    endcase
    sum_waddr = (state_q == StIdle) ? to_addr(in_item_i.vertex_index) : to_addr(corner);

    attr_wdata.pos_x = in_item_i.pos_x;
    attr_wdata.pos_y = in_item_i.pos_y;
    attr_wdata.pos_z = in_item_i.pos_z;
    attr_wdata.tex_u = in_item_i.tex_u;
    attr_wdata.tex_v = in_item_i.tex_v;

    if (state_q == StIdle) begin
      sum_wdata = '0;
    end else begin
      for (int i = 0; i < 6; i++) begin
        sum_wdata.sums[5-i] = sat_add48(sum_rdata_q.sums[5-i], res_q[i]);
      end
      sum_wdata.count = (sum_rdata_q.count == 16'hFFFF) ? 16'hFFFF
                                                        : 16'(sum_rdata_q.count + 16'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (attr_we) begin
      attr_mem[to_addr(in_item_i.vertex_index)] <= attr_wdata;
    end
    attr_rdata_q <= attr_mem[attr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rdata_q <= sum_mem[sum_raddr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    kc_d      = kc_q;
    mstep_d   = mstep_q;
    done_d    = 1'b0;
    result_d  = '0;
    attr_we   = 1'b0;
    sum_we    = 1'b0;
    take_item = 1'b0;
    take_a    = 1'b0;
    take_p    = 1'b0;
    take_q    = 1'b0;
    take_res  = 1'b0;
    div_start = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          take_item = 1'b1;
          case (in_item_i.operation)
            OpLoad: begin
              attr_we = in_range(in_item_i.vertex_index);
              sum_we  = in_range(in_item_i.vertex_index);
              done_d  = 1'b1;
            end
            OpAccum: begin
              if (in_range(in_item_i.corner_a) && in_range(in_item_i.corner_b) &&
                  in_range(in_item_i.corner_c)) begin
                state_d = StLdA;
              end else begin
                done_d = 1'b1;
                result_d.triangle_skipped = 1'b1;
              end
            end
            OpRead: begin
              if (in_range(in_item_i.vertex_index)) begin
                state_d = StRdSum;
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      StLdA: state_d = StLdB;
      StLdB: begin
        take_a  = 1'b1;
        state_d = StLdC;
      end
      StLdC: begin
        take_p  = 1'b1;
        state_d = StDelta;
      end
      StDelta: begin
        take_q  = 1'b1;
        mstep_d = 4'd0;
        state_d = StMul;
      end
      StMul: begin
        mstep_d = 4'(mstep_q + 4'd1);
        if (mstep_q == 4'd13) begin
          state_d = StDet;
        end
      end
      StDet: begin
        if (det_skip) begin
          done_d = 1'b1;
          result_d.triangle_skipped = 1'b1;
          state_d = StIdle;
        end else begin
          k_d     = 3'd0;
          state_d = StDivIss;
        end
      end
      StRdSum: begin
        if (sum_rdata_q.count == 16'd0) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          k_d     = 3'd0;
          state_d = StDivIss;
        end
      end
      StDivIss: begin
        div_start = 1'b1;
        state_d   = StDivWait;
      end
      StDivWait: begin
        if (div_done) begin
          take_res = 1'b1;
          if (k_q == 3'd5) begin
            if (item_q.operation == OpRead) begin
              done_d = 1'b1;
              result_d.tangent_x   = res_q[0];
              result_d.tangent_y   = res_q[1];
              result_d.tangent_z   = res_q[2];
              result_d.bitangent_x = res_q[3];
              result_d.bitangent_y = res_q[4];
              result_d.bitangent_z = div_quot;
              result_d.share_count = sum_rdata_q.count;
              state_d = StIdle;
            end else begin
              kc_d    = 2'd0;
              state_d = StRmwRd;
            end
          end else begin
            k_d     = 3'(k_q + 3'd1);
            state_d = StDivIss;
          end
        end
      end
      StRmwRd: state_d = StRmwWr;
      StRmwWr: begin
        sum_we = 1'b1;
        if (kc_q == 2'd2) begin
          done_d = 1'b1;
          result_d.tangent_x   = res_q[0];
          result_d.tangent_y   = res_q[1];
          result_d.tangent_z   = res_q[2];
          result_d.bitangent_x = res_q[3];
          result_d.bitangent_y = res_q[4];
          result_d.bitangent_z = res_q[5];
          state_d = StIdle;
        end else begin
          kc_d    = 2'(kc_q + 2'd1);
          state_d = StRmwRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= 3'd0;
      kc_q    <= 2'd0;
      mstep_q <= 4'd0;
      done_q  <= 1'b0;
      mv_q    <= 1'b0;
      mj_q    <= 4'd0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      kc_q    <= kc_d;
      mstep_q <= mstep_d;
      done_q  <= done_d;
      mv_q    <= (state_q == StMul);
      mj_q    <= mstep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (take_item) begin
      item_q <= in_item_i;
    end
    if (take_a) begin
      a_q <= attr_rdata_q;
    end
    if (take_p) begin
      p_q[0] <= sat_sub32(attr_rdata_q.pos_x, a_q.pos_x);
      p_q[1] <= sat_sub32(attr_rdata_q.pos_y, a_q.pos_y);
      p_q[2] <= sat_sub32(attr_rdata_q.pos_z, a_q.pos_z);
      pu_q   <= sat_sub32(attr_rdata_q.tex_u, a_q.tex_u);
      pv_q   <= sat_sub32(attr_rdata_q.tex_v, a_q.tex_v);
    end
    if (take_q) begin
      qd_q[0] <= sat_sub32(attr_rdata_q.pos_x, a_q.pos_x);
      qd_q[1] <= sat_sub32(attr_rdata_q.pos_y, a_q.pos_y);
      qd_q[2] <= sat_sub32(attr_rdata_q.pos_z, a_q.pos_z);
      qu_q    <= sat_sub32(attr_rdata_q.tex_u, a_q.tex_u);
      qv_q    <= sat_sub32(attr_rdata_q.tex_v, a_q.tex_v);
    end
    // first term of a pair loads, second term subtracts and stores
    if (mv_q) begin
      if (!mj_q[0]) begin
        acc_q <= prod;
      end else begin
        num_q[mj_q[3:1]] <= acc_q - prod;
      end
    end
    if (take_res) begin
      res_q[k_q] <= div_quot;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
